FILE: hw/rtl/dpalu_pkg.sv
`default_nettype none

package dpalu_pkg;

   localparam int unsigned NUM_REGS   = 16;
   localparam int unsigned REG_ADDR_W = 4;
   localparam int unsigned DATA_W     = 32;

   localparam logic [REG_ADDR_W-1:0] PC_REG = 4'd15;
   localparam logic [DATA_W-1:0]     THUMB_PC_OFFSET = 32'd2;
   localparam logic [7:0]            SHIFT_FULL = 8'd32;

   // NZCV bit positions
   localparam int unsigned FLAG_N = 3;
   localparam int unsigned FLAG_Z = 2;
   localparam int unsigned FLAG_C = 1;
   localparam int unsigned FLAG_V = 0;

   typedef enum logic [4:0] {
      OP_AND   = 5'd0,
      OP_EOR   = 5'd1,
      OP_SUB   = 5'd2,
      OP_RSB   = 5'd3,
      OP_ADD   = 5'd4,
      OP_ADC   = 5'd5,
      OP_SBC   = 5'd6,
      OP_RSC   = 5'd7,
      OP_TST   = 5'd8,
      OP_TEQ   = 5'd9,
      OP_CMP   = 5'd10,
      OP_CMN   = 5'd11,
      OP_ORR   = 5'd12,
      OP_MOV   = 5'd13,
      OP_BIC   = 5'd14,
      OP_MVN   = 5'd15,
      OP_LSL   = 5'd16,
      OP_LSR   = 5'd17,
      OP_ASR   = 5'd18,
      OP_ROR   = 5'd19,
      OP_NEG   = 5'd20,
      OP_MUL   = 5'd21,
      OP_TADD  = 5'd22
   } opcode_type;

   typedef struct packed {
      logic [4:0]            opcode;
      logic [REG_ADDR_W-1:0] src_index;
      logic [REG_ADDR_W-1:0] dst_index;
      logic [DATA_W-1:0]     second_operand;
      logic                  set_flags;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              wrote_register;
      logic [3:0]        flags;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: hw/rtl/dpalu_stream_if.sv
`default_nettype none

interface dpalu_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dpalu_ram.sv
`default_nettype none

module dpalu_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dpalu_alu.sv
`default_nettype none

module dpalu_alu #(
   parameter int unsigned PC_OFFSET = 4
) (
   input  wire dpalu_pkg::req_payload_type req,
   input  wire logic [31:0]                src_data,
   input  wire logic [31:0]                dst_data,
   input  wire logic [3:0]                 nzcv,
   output dpalu_pkg::rsp_payload_type      res
);

   localparam logic [31:0] PC_ADJ = 32'(PC_OFFSET);

   logic        cin;
   logic [31:0] op2;
   logic [31:0] a_cmp;
   logic [31:0] add_a;
   logic [31:0] add_b;
   logic        add_c;
   logic [32:0] sum;
   logic [31:0] add_r;
   logic        add_v;

   logic [7:0]  sh_n;
   logic [4:0]  sh_amt;
   logic        sh_big;
   logic        sh_eq32;
   logic [32:0] lsl_w;
   logic [32:0] lsr_w;
   logic [32:0] asr_w;
   logic [63:0] ror_w;
   logic [31:0] sh_r;
   logic        sh_c;

   logic [31:0] mul_r;
   logic [31:0] alu_r;
   logic [3:0]  flags;
   logic        wrote;
   logic        use_off;
   logic [31:0] offset;

   function automatic logic [1:0] nz_of(input logic [31:0] r);
      return {r[31], (r == 32'd0)};
   endfunction

   assign cin   = nzcv[dpalu_pkg::FLAG_C];
   assign op2   = req.second_operand;
   assign a_cmp = (req.src_index == dpalu_pkg::PC_REG) ? src_data + PC_ADJ : src_data;
   assign mul_r = src_data * op2;

   // adder operand select
   always_comb begin
      add_a = src_data;
      add_b = op2;
      add_c = 1'b0;
      case (dpalu_pkg::opcode_type'(req.opcode))
         dpalu_pkg::OP_SUB: begin add_b = ~op2; add_c = 1'b1; end
         dpalu_pkg::OP_RSB: begin add_a = op2; add_b = ~src_data; add_c = 1'b1; end
         dpalu_pkg::OP_ADC: begin add_c = cin; end
         dpalu_pkg::OP_SBC: begin add_b = ~op2; add_c = cin; end
         dpalu_pkg::OP_RSC: begin add_a = op2; add_b = ~src_data; add_c = cin; end
         dpalu_pkg::OP_CMP: begin add_a = a_cmp; add_b = ~op2; add_c = 1'b1; end
         dpalu_pkg::OP_NEG: begin add_a = 32'd0; add_b = ~op2; add_c = 1'b1; end
         default: begin end
      endcase
   end

   assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_c};
   assign add_r = sum[31:0];
   assign add_v = (add_a[31] ^ add_r[31]) & (add_b[31] ^ add_r[31]);

   // shifter
   assign sh_n    = op2[7:0];
   assign sh_amt  = sh_n[4:0];
   assign sh_big  = |sh_n[7:5];
   assign sh_eq32 = (sh_n == dpalu_pkg::SHIFT_FULL);
   assign lsl_w   = {1'b0, dst_data} << sh_amt;
   assign lsr_w   = {dst_data, 1'b0} >> sh_amt;
   assign asr_w   = 33'($signed({dst_data, 1'b0}) >>> sh_amt);
   assign ror_w   = {dst_data, dst_data} >> sh_amt;

   always_comb begin
      sh_r = dst_data;
      sh_c = cin;
      if (sh_n != 8'd0) begin
         case (dpalu_pkg::opcode_type'(req.opcode))
            dpalu_pkg::OP_LSL: begin
               if (!sh_big) begin
                  sh_r = lsl_w[31:0];
                  sh_c = lsl_w[32];
               end else begin
                  sh_r = 32'd0;
                  sh_c = sh_eq32 & dst_data[0];
               end
            end
            dpalu_pkg::OP_LSR: begin
               if (!sh_big) begin
                  sh_r = lsr_w[32:1];
                  sh_c = lsr_w[0];
               end else begin
                  sh_r = 32'd0;
                  sh_c = sh_eq32 & dst_data[31];
               end
            end
            dpalu_pkg::OP_ASR: begin
               if (!sh_big) begin
                  sh_r = asr_w[32:1];
                  sh_c = asr_w[0];
               end else begin
                  sh_r = {32{dst_data[31]}};
                  sh_c = dst_data[31];
               end
            end
            default: begin
               // rotate: a multiple of 32 leaves the value and takes C from bit 31
               sh_r = ror_w[31:0];
               sh_c = ror_w[31];
            end
         endcase
      end
   end

   always_comb begin
      alu_r   = 32'd0;
      flags   = nzcv;
      wrote   = 1'b0;
      use_off = 1'b1;
      offset  = PC_ADJ;
      case (dpalu_pkg::opcode_type'(req.opcode))
         dpalu_pkg::OP_AND, dpalu_pkg::OP_EOR, dpalu_pkg::OP_ORR,
         dpalu_pkg::OP_MOV, dpalu_pkg::OP_BIC, dpalu_pkg::OP_MVN: begin
            case (dpalu_pkg::opcode_type'(req.opcode))
               dpalu_pkg::OP_AND: alu_r = src_data & op2;
               dpalu_pkg::OP_EOR: alu_r = src_data ^ op2;
               dpalu_pkg::OP_ORR: alu_r = src_data | op2;
               dpalu_pkg::OP_MOV: alu_r = op2;
               dpalu_pkg::OP_BIC: alu_r = src_data & ~op2;
               default:           alu_r = ~op2;
            endcase
            wrote = 1'b1;
            if (req.set_flags) begin
               flags[3:2] = nz_of(alu_r);
            end
         end
         dpalu_pkg::OP_SUB, dpalu_pkg::OP_RSB, dpalu_pkg::OP_ADD, dpalu_pkg::OP_ADC,
         dpalu_pkg::OP_SBC, dpalu_pkg::OP_RSC, dpalu_pkg::OP_NEG, dpalu_pkg::OP_TADD: begin
            alu_r = add_r;
            wrote = 1'b1;
            if (dpalu_pkg::opcode_type'(req.opcode) == dpalu_pkg::OP_NEG) begin
               use_off = 1'b0;
            end
            if (dpalu_pkg::opcode_type'(req.opcode) == dpalu_pkg::OP_TADD) begin
               offset = dpalu_pkg::THUMB_PC_OFFSET;
            end
            if (req.set_flags) begin
               flags = {nz_of(add_r), sum[32], add_v};
            end
         end
         dpalu_pkg::OP_TST: begin
            alu_r = src_data & op2;
            flags[3:2] = nz_of(alu_r);
         end
         dpalu_pkg::OP_TEQ: begin
            alu_r = src_data ^ op2;
            flags[3:2] = nz_of(alu_r);
         end
         dpalu_pkg::OP_CMP, dpalu_pkg::OP_CMN: begin
            alu_r = add_r;
            flags = {nz_of(add_r), sum[32], add_v};
         end
         dpalu_pkg::OP_LSL, dpalu_pkg::OP_LSR, dpalu_pkg::OP_ASR, dpalu_pkg::OP_ROR: begin
            alu_r = sh_r;
            wrote = 1'b1;
            use_off = 1'b0;
            flags[3:1] = {nz_of(sh_r), sh_c};
         end
         dpalu_pkg::OP_MUL: begin
            alu_r = mul_r;
            wrote = 1'b1;
            use_off = 1'b0;
            flags[3:2] = nz_of(mul_r);
         end
         default: begin end
      endcase
   end

   // flags use the pre-offset value; PC writes drop the offset, but not NEG/shift/MUL
   always_comb begin
      res.value          = alu_r;
      res.wrote_register = wrote;
      res.flags          = flags;
      if (wrote && use_off && (req.dst_index == dpalu_pkg::PC_REG)) begin
         res.value = alu_r - offset;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/arm_data_processing_alu.sv
// ARM-style data-processing ALU with a sixteen-entry register file and NZCV flags.
//
// req_if carries one instruction per transfer (opcode, source and destination
// register indexes, second operand, set-flags bit); rsp_if returns one result per
// instruction: the value, whether it was written back, and NZCV after the step.
// Results come out in instruction order.
//
// Throughput: one instruction per cycle while the receiver takes results. The request
// transfer edge also loads the registered read of the register-file RAM; the edge on
// which execute fires then executes, writes back and loads the output register that
// drives rsp_if.valid. A write from the instruction just ahead is forwarded to the
// next one.
//
// Reset clears the flags, the pipeline and a valid bit per register, so every
// register reads as zero until written. When the receiver stalls, the result
// holds in the output register, the next instruction waits in execute, and
// req_if.ready drops only once both are occupied.
`default_nettype none

module arm_data_processing_alu #(
   parameter int unsigned PC_OFFSET = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   dpalu_stream_if.sink    req_if,
   dpalu_stream_if.source  rsp_if
);

   localparam int unsigned AW = dpalu_pkg::REG_ADDR_W;

   logic                           req_xfer;
   logic                           ex_fire;
   logic                           ex_valid_ff, ex_valid_in;
   dpalu_pkg::req_payload_type     ex_req_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   dpalu_pkg::rsp_payload_type     rsp_data_ff;
   logic [3:0]                     nzcv_ff, nzcv_in;
   logic [dpalu_pkg::NUM_REGS-1:0] reg_valid_ff, reg_valid_in;
   logic                           src_valid_ff;
   logic                           dst_valid_ff;
   logic                           fwd_en_ff;
   logic [AW-1:0]                  fwd_addr_ff;
   logic [31:0]                    fwd_data_ff;
   logic [31:0]                    ram_src;
   logic [31:0]                    ram_dst;
   logic [31:0]                    src_data;
   logic [31:0]                    dst_data;
   dpalu_pkg::rsp_payload_type     alu_res;
   logic                           wr_en;

   assign ex_fire      = ex_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !ex_valid_ff || ex_fire;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign wr_en        = ex_fire && alu_res.wrote_register;

   dpalu_ram #(
      .WIDTH (32),
      .DEPTH (dpalu_pkg::NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (ex_req_ff.dst_index),
      .wr_data   (alu_res.value),
      .rd_en     (req_xfer),
      .rd_addr_a (req_if.data.src_index),
      .rd_addr_b (req_if.data.dst_index),
      .rd_data_a (ram_src),
      .rd_data_b (ram_dst)
   );

   // forward the last executed write, which may have landed at the same edge as this read
   always_comb begin
      src_data = src_valid_ff ? ram_src : 32'd0;
      dst_data = dst_valid_ff ? ram_dst : 32'd0;
      if (fwd_en_ff && (fwd_addr_ff == ex_req_ff.src_index)) begin
         src_data = fwd_data_ff;
      end
      if (fwd_en_ff && (fwd_addr_ff == ex_req_ff.dst_index)) begin
         dst_data = fwd_data_ff;
      end
   end

   dpalu_alu #(
      .PC_OFFSET (PC_OFFSET)
   ) u_alu (
      .req      (ex_req_ff),
      .src_data (src_data),
      .dst_data (dst_data),
      .nzcv     (nzcv_ff),
      .res      (alu_res)
   );

   always_comb begin
      ex_valid_in  = ex_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      nzcv_in      = nzcv_ff;
      reg_valid_in = reg_valid_ff;
      if (ex_fire) begin
         ex_valid_in = 1'b0;
         nzcv_in     = alu_res.flags;
      end
      if (req_xfer) begin
         ex_valid_in = 1'b1;
      end
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ex_fire) begin
         rsp_valid_in = 1'b1;
      end
      if (wr_en) begin
         reg_valid_in[ex_req_ff.dst_index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         nzcv_ff      <= 4'd0;
         reg_valid_ff <= '0;
         fwd_en_ff    <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         nzcv_ff      <= nzcv_in;
         reg_valid_ff <= reg_valid_in;
         if (ex_fire) begin
            fwd_en_ff <= alu_res.wrote_register;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ex_req_ff    <= req_if.data;
         src_valid_ff <= reg_valid_ff[req_if.data.src_index];
         dst_valid_ff <= reg_valid_ff[req_if.data.dst_index];
      end
      if (ex_fire) begin
         fwd_addr_ff <= ex_req_ff.dst_index;
         fwd_data_ff <= alu_res.value;
         rsp_data_ff <= alu_res;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_stall_holds_execute: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !ex_fire)
      else $error("execute advanced into a stalled output register");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> reg_valid_ff[$past(ex_req_ff.dst_index)])
      else $error("written register not marked valid");

   a_flags_only_on_fire: assert property (@(posedge clock) disable iff (reset)
      !ex_fire |=> $stable(nzcv_ff))
      else $error("flags changed without an executed instruction");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_if.valid && !ex_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

FILE: dv/arm_data_processing_alu_tb.sv
module arm_data_processing_alu_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PC_OFFSET    = 4;
   localparam int unsigned IDLE_PCT     = 24;
   localparam int unsigned CYCLE_LIMIT  = 200_000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned STALL_CYCLES = 60;

   // opcodes the block ignores
   localparam logic [4:0] OP_UNUSED_MIN = 5'd23;
   localparam logic [4:0] OP_UNUSED_MAX = 5'd31;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dpalu_stream_if #(.payload_type(dpalu_pkg::req_payload_type)) req_ch ();
   dpalu_stream_if #(.payload_type(dpalu_pkg::rsp_payload_type)) rsp_ch ();

   arm_data_processing_alu #(.PC_OFFSET(PC_OFFSET)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // architectural state as seen by the predictor
   logic [31:0]                arch_regs [dpalu_pkg::NUM_REGS];
   logic [3:0]                 arch_flags;
   dpalu_pkg::rsp_payload_type pending_results [$];

   int errors;
   int instr_count;
   int result_count;
   int cycle_count;
   bit idle_on;
   int hold_request;
   int hold_left;

   function automatic void add_carry(input logic [31:0] x, input logic [31:0] y,
                                     input logic cin, output logic [31:0] sum,
                                     output logic cout, output logic ovf);
      logic [32:0] wide;
      wide = {1'b0, x} + {1'b0, y} + {32'd0, cin};
      sum  = wide[31:0];
      cout = wide[32];
      ovf  = (x[31] == y[31]) && (sum[31] != x[31]);
   endfunction

   // Execute one instruction on the architectural state and return its result.
   function automatic dpalu_pkg::rsp_payload_type execute_instr(
         input dpalu_pkg::req_payload_type instr);
      logic [31:0]                a, op2, x, r, pc_adjust;
      logic                       cin, c, v, write, apply_adjust, upd_nz, upd_c, upd_v, sf;
      int unsigned                amount, m;
      dpalu_pkg::rsp_payload_type res;
      a            = arch_regs[instr.src_index];
      op2          = instr.second_operand;
      sf           = instr.set_flags;
      cin          = arch_flags[dpalu_pkg::FLAG_C];
      r            = '0;
      c            = cin;
      v            = arch_flags[dpalu_pkg::FLAG_V];
      write        = 1'b0;
      apply_adjust = 1'b1;
      pc_adjust    = PC_OFFSET;
      upd_nz       = 1'b0;
      upd_c        = 1'b0;
      upd_v        = 1'b0;
      case (instr.opcode)
         dpalu_pkg::OP_AND: begin r = a & op2;  write = 1'b1; upd_nz = sf; end
         dpalu_pkg::OP_EOR: begin r = a ^ op2;  write = 1'b1; upd_nz = sf; end
         dpalu_pkg::OP_ORR: begin r = a | op2;  write = 1'b1; upd_nz = sf; end
         dpalu_pkg::OP_MOV: begin r = op2;      write = 1'b1; upd_nz = sf; end
         dpalu_pkg::OP_BIC: begin r = a & ~op2; write = 1'b1; upd_nz = sf; end
         dpalu_pkg::OP_MVN: begin r = ~op2;     write = 1'b1; upd_nz = sf; end
         dpalu_pkg::OP_SUB: begin
            add_carry(a, ~op2, 1'b1, r, c, v);
            write = 1'b1; {upd_nz, upd_c, upd_v} = {3{sf}};
         end
         dpalu_pkg::OP_RSB: begin
            add_carry(op2, ~a, 1'b1, r, c, v);
            write = 1'b1; {upd_nz, upd_c, upd_v} = {3{sf}};
         end
         dpalu_pkg::OP_ADD: begin
            add_carry(a, op2, 1'b0, r, c, v);
            write = 1'b1; {upd_nz, upd_c, upd_v} = {3{sf}};
         end
         dpalu_pkg::OP_ADC: begin
            add_carry(a, op2, cin, r, c, v);
            write = 1'b1; {upd_nz, upd_c, upd_v} = {3{sf}};
         end
         dpalu_pkg::OP_SBC: begin
            add_carry(a, ~op2, cin, r, c, v);
            write = 1'b1; {upd_nz, upd_c, upd_v} = {3{sf}};
         end
         dpalu_pkg::OP_RSC: begin
            add_carry(op2, ~a, cin, r, c, v);
            write = 1'b1; {upd_nz, upd_c, upd_v} = {3{sf}};
         end
         dpalu_pkg::OP_TST: begin r = a & op2; upd_nz = 1'b1; end
         dpalu_pkg::OP_TEQ: begin r = a ^ op2; upd_nz = 1'b1; end
         dpalu_pkg::OP_CMP: begin
            // reading the PC sees it ahead by the pipeline offset
            if (instr.src_index == dpalu_pkg::PC_REG) a = a + PC_OFFSET;
            add_carry(a, ~op2, 1'b1, r, c, v);
            {upd_nz, upd_c, upd_v} = 3'b111;
         end
         dpalu_pkg::OP_CMN: begin
            add_carry(a, op2, 1'b0, r, c, v);
            {upd_nz, upd_c, upd_v} = 3'b111;
         end
         dpalu_pkg::OP_LSL, dpalu_pkg::OP_LSR, dpalu_pkg::OP_ASR, dpalu_pkg::OP_ROR: begin
            x      = arch_regs[instr.dst_index];
            amount = 32'(op2[7:0]);
            r      = x;
            if (amount != 0) begin
               if (instr.opcode == dpalu_pkg::OP_LSL) begin
                  if (amount < 32) begin
                     r = x << amount;
                     c = x[32 - amount];
                  end else begin
                     r = '0;
                     c = (amount == 32) ? x[0] : 1'b0;
                  end
               end else if (instr.opcode == dpalu_pkg::OP_LSR) begin
                  if (amount < 32) begin
                     r = x >> amount;
                     c = x[amount - 1];
                  end else begin
                     r = '0;
                     c = (amount == 32) ? x[31] : 1'b0;
                  end
               end else if (instr.opcode == dpalu_pkg::OP_ASR) begin
                  if (amount < 32) begin
                     r = $signed(x) >>> amount;
                     c = x[amount - 1];
                  end else begin
                     r = {32{x[31]}};
                     c = x[31];
                  end
               end else begin
                  m = amount % 32;
                  if (m == 0) begin
                     c = x[31];
                  end else begin
                     r = (x >> m) | (x << (32 - m));
                     c = r[31];
                  end
               end
            end
            write = 1'b1; apply_adjust = 1'b0; upd_nz = 1'b1; upd_c = 1'b1;
         end
         dpalu_pkg::OP_NEG: begin
            add_carry(32'd0, ~op2, 1'b1, r, c, v);
            write = 1'b1; apply_adjust = 1'b0; {upd_nz, upd_c, upd_v} = {3{sf}};
         end
         dpalu_pkg::OP_MUL: begin
            r = a * op2;
            write = 1'b1; apply_adjust = 1'b0; upd_nz = 1'b1;
         end
         dpalu_pkg::OP_TADD: begin
            add_carry(a, op2, 1'b0, r, c, v);
            write = 1'b1; pc_adjust = dpalu_pkg::THUMB_PC_OFFSET;
            {upd_nz, upd_c, upd_v} = {3{sf}};
         end
         default: ;
      endcase
      // flags come from the value before the PC adjustment
      if (upd_nz) begin
         arch_flags[dpalu_pkg::FLAG_N] = r[31];
         arch_flags[dpalu_pkg::FLAG_Z] = (r == 32'd0);
      end
      if (upd_c) arch_flags[dpalu_pkg::FLAG_C] = c;
      if (upd_v) arch_flags[dpalu_pkg::FLAG_V] = v;
      if (write) begin
         if (apply_adjust && instr.dst_index == dpalu_pkg::PC_REG) r = r - pc_adjust;
         arch_regs[instr.dst_index] = r;
      end
      res.value          = r;
      res.wrote_register = write;
      res.flags          = arch_flags;
      return res;
   endfunction

   // Predict on every request transfer; compare every result transfer.
   always @(posedge clock) begin
      dpalu_pkg::rsp_payload_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: value %h", rsp_ch.data.value);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.data.value !== want.value) begin
                  $error("value mismatch: expected %h, got %h", want.value, rsp_ch.data.value);
                  errors++;
               end
               if (rsp_ch.data.wrote_register !== want.wrote_register) begin
                  $error("wrote_register mismatch: expected %b, got %b",
                         want.wrote_register, rsp_ch.data.wrote_register);
                  errors++;
               end
               if (rsp_ch.data.flags !== want.flags) begin
                  $error("flags mismatch: expected %b, got %b", want.flags, rsp_ch.data.flags);
                  errors++;
               end
               result_count++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_results.push_back(execute_instr(req_ch.data));
            instr_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result receiver: a requested hold, else random stalls if idle_on, else ready.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (idle_on) begin
         rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic dpalu_pkg::req_payload_type make_instr(input logic [4:0] op,
                                                             input logic [3:0] src,
                                                             input logic [3:0] dst,
                                                             input logic [31:0] op2,
                                                             input logic sf);
      dpalu_pkg::req_payload_type instr;
      instr.opcode         = op;
      instr.src_index      = src;
      instr.dst_index      = dst;
      instr.second_operand = op2;
      instr.set_flags      = sf;
      return instr;
   endfunction

   function automatic dpalu_pkg::req_payload_type random_instr();
      dpalu_pkg::req_payload_type instr;
      logic [4:0]                 op;
      if ($urandom_range(19) == 0) begin
         op = 5'($urandom_range(OP_UNUSED_MAX, OP_UNUSED_MIN));
      end else begin
         op = 5'($urandom_range(dpalu_pkg::OP_TADD, dpalu_pkg::OP_AND));
      end
      instr.opcode    = op;
      instr.src_index = 4'($urandom_range(15));
      instr.dst_index = 4'($urandom_range(15));
      instr.set_flags = 1'($urandom_range(1));
      if (op >= dpalu_pkg::OP_LSL && op <= dpalu_pkg::OP_ROR && $urandom_range(9) < 7) begin
         instr.second_operand = $urandom_range(40);
      end else begin
         case ($urandom_range(7))
            0:       instr.second_operand = 32'd0;
            1:       instr.second_operand = 32'hFFFF_FFFF;
            2:       instr.second_operand = 32'h8000_0000;
            3:       instr.second_operand = 32'h7FFF_FFFF;
            4:       instr.second_operand = $urandom_range(255);
            default: instr.second_operand = $urandom;
         endcase
      end
      return instr;
   endfunction

   task automatic send_instr(input dpalu_pkg::req_payload_type instr);
      if (idle_on) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.data  <= instr;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_instr(make_instr(dpalu_pkg::OP_MOV, 4'd0, 4'd1, 32'hFFFF_FFFF, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_MOV, 4'd0, 4'd2, 32'h8000_0000, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_ADD, 4'd1, 4'd3, 32'd1, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_ADC, 4'd2, 4'd4, 32'h8000_0000, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_SUB, 4'd2, 4'd5, 32'd1, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_RSB, 4'd5, 4'd6, 32'd0, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_SBC, 4'd0, 4'd7, 32'd1, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_RSC, 4'd1, 4'd8, 32'h7FFF_FFFF, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_AND, 4'd1, 4'd9, 32'hF0F0_F0F0, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_EOR, 4'd9, 4'd10, 32'hFFFF_FFFF, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_ORR, 4'd0, 4'd11, 32'd0, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_BIC, 4'd1, 4'd12, 32'h0000_FFFF, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_MVN, 4'd0, 4'd13, 32'd0, 1'b1));
      // write the PC, then compare against it through the read offset
      send_instr(make_instr(dpalu_pkg::OP_MOV, 4'd0, dpalu_pkg::PC_REG, 32'h0000_1000, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_CMP, dpalu_pkg::PC_REG, 4'd0, 32'h0000_1000, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_CMN, 4'd1, 4'd0, 32'd1, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_TST, 4'd2, 4'd0, 32'h8000_0000, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_TEQ, 4'd1, 4'd0, 32'hFFFF_FFFF, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_LSL, 4'd0, 4'd13, 32'd33, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_LSR, 4'd0, 4'd2, 32'd32, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_ASR, 4'd0, 4'd12, 32'd200, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_ROR, 4'd0, 4'd6, 32'd64, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_LSL, 4'd0, 4'd5, 32'h0000_0100, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_NEG, 4'd0, dpalu_pkg::PC_REG, 32'd1, 1'b1));
      send_instr(make_instr(dpalu_pkg::OP_MUL, 4'd6, 4'd7, 32'hFFFF_FFFF, 1'b0));
      send_instr(make_instr(dpalu_pkg::OP_TADD, 4'd1, dpalu_pkg::PC_REG, 32'h0000_0010, 1'b1));
      send_instr(make_instr(OP_UNUSED_MAX, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1));
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_instr(random_instr());
   endtask

   // Stall the receiver long enough to fill the pipe while requests keep coming.
   task automatic test_backpressure();
      idle_on = 1'b0;
      @(posedge clock);
      hold_request = STALL_CYCLES;
      repeat (30) send_instr(random_instr());
      wait_for_results();
      idle_on = 1'b1;
   endtask

   task automatic test_steady_stream(input int count);
      idle_on = 1'b0;
      repeat (count) send_instr(random_instr());
      idle_on = 1'b1;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      errors       = 0;
      instr_count  = 0;
      result_count = 0;
      cycle_count  = 0;
      idle_on      = 1'b1;
      hold_request = 0;
      hold_left    = 0;
      arch_flags   = '0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(250);
      test_backpressure();
      test_steady_stream(100);
      test_random_mix(60);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d instructions and checked %0d results:", instr_count, result_count);
      $display("  all opcodes incl. unused ones, PC offsets, shift edges, long output stall");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/dpalu_pkg.sv
hw/rtl/dpalu_stream_if.sv
hw/rtl/dpalu_ram.sv
hw/rtl/dpalu_alu.sv
hw/rtl/arm_data_processing_alu.sv
dv/arm_data_processing_alu_tb.sv
